@@ rtl/core/strided_tensor_offset_generator_defines.svh @@
`ifndef STRIDED_TENSOR_OFFSET_GENERATOR_DEFINES_SVH
`define STRIDED_TENSOR_OFFSET_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define STOG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stog assertion failed");
`define STOG_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stog assertion failed");
`else
`define STOG_ASSERT(lbl, clk, rst_n, prop)
`define STOG_ASSERT_NR(lbl, clk, prop)
`endif

`endif

@@ rtl/core/stog_pkg.sv @@
package stog_pkg;

  localparam int DIM_COUNT      = 4;
  localparam int INDEX_W        = 32;
  localparam int SIZE_W         = 16;
  localparam int STRIDE_W       = 32;
  localparam int OFFSET_W       = 64;
  localparam int PROD_W         = SIZE_W + STRIDE_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = INDEX_W / BITS_PER_STAGE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_SIZE_0,
    CFG_DIM_SIZE_1,
    CFG_DIM_SIZE_2,
    CFG_DIM_SIZE_3,
    CFG_STRIDE_0,
    CFG_STRIDE_1,
    CFG_STRIDE_2,
    CFG_STRIDE_3
  } cfg_reg_t;

  // one request in flight through the divide chain
  typedef struct packed {
    logic                                valid;
    logic [INDEX_W-1:0]                  rest;
    logic [DIM_COUNT-1:0][SIZE_W-1:0]    coord;
  } div_item_t;

endpackage

@@ rtl/core/stog_div.sv @@
`include "strided_tensor_offset_generator_defines.svh"

module stog_div
  import stog_pkg::*;
#(
  parameter int DIM = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [SIZE_W-1:0] divisor,
  input  div_item_t         item_in,
  output div_item_t         item_out
);

  localparam int LAST = DIV_STAGES - 1;

  div_item_t         item_r [DIV_STAGES];
  logic [SIZE_W-1:0] rem_r  [DIV_STAGES];

  // restoring division, BITS_PER_STAGE quotient bits per stage;
  // rest doubles as dividend shift-out and quotient shift-in
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_item_t         item_prev;
    logic [SIZE_W-1:0] rem_prev;
    div_item_t         item_nxt;
    logic [SIZE_W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign item_prev = item_in;
      assign rem_prev  = '0;
    end else begin : g_chain
      assign item_prev = item_r[s-1];
      assign rem_prev  = rem_r[s-1];
    end

    always_comb begin
      logic [SIZE_W:0]    part;
      logic [INDEX_W-1:0] sh;
      part = {1'b0, rem_prev};
      sh   = item_prev.rest;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        part = {part[SIZE_W-1:0], sh[INDEX_W-1]};
        sh   = {sh[INDEX_W-2:0], 1'b0};
        if (part >= {1'b0, divisor}) begin
          part  = part - {1'b0, divisor};
          sh[0] = 1'b1;
        end
      end
      item_nxt      = item_prev;
      item_nxt.rest = sh;
      rem_nxt       = part[SIZE_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        item_r[s].valid <= 1'b0;
      end else if (en) begin
        item_r[s] <= item_nxt;
        rem_r[s]  <= rem_nxt;
      end
    end
  end

  always_comb begin
    item_out            = item_r[LAST];
    item_out.coord[DIM] = rem_r[LAST];
  end

  `STOG_ASSERT(a_rem_below_divisor, clk, rst_n, item_r[LAST].valid |-> rem_r[LAST] < divisor)

endmodule

@@ rtl/core/strided_tensor_offset_generator.sv @@
// Strided tensor offset generator. Each request carries a row-major linear
// index; the block splits it into four coordinates against the configured
// dimension sizes (innermost first, the index wrapping modulo the tensor's
// extent) and returns them with the element offset sum(coord * stride).
// One request is taken every cycle while out_stall is low. The pipeline is
// four dividers of eight stages each (four quotient bits per stage), one
// multiply stage, one add stage and the output register. A stalled output
// freezes the whole pipeline, so in_stall follows out_stall while a result
// is held. Dimension size zero acts as one. Configuration must be written
// only while the pipeline is empty; the block does not enforce this.
`include "strided_tensor_offset_generator_defines.svh"

module strided_tensor_offset_generator
  import stog_pkg::*;
#(
  parameter int NUM_DIMS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [INDEX_W-1:0]    in_linear_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SIZE_W-1:0]     out_coord_0,
  output logic [SIZE_W-1:0]     out_coord_1,
  output logic [SIZE_W-1:0]     out_coord_2,
  output logic [SIZE_W-1:0]     out_coord_3,
  output logic [OFFSET_W-1:0]   out_element_offset
);

  localparam int ACTIVE    = (NUM_DIMS < 1) ? 1 :
                             (NUM_DIMS > DIM_COUNT) ? DIM_COUNT : NUM_DIMS;
  localparam int FIRST_DIM = DIM_COUNT - ACTIVE;

  logic [SIZE_W-1:0]   dim_size_r [DIM_COUNT];
  logic [STRIDE_W-1:0] stride_r   [DIM_COUNT];
  logic [SIZE_W-1:0]   div_size   [DIM_COUNT];

  logic                             adv;
  div_item_t                        chain [DIM_COUNT+1];
  logic [PROD_W-1:0]                prod_nxt [DIM_COUNT];

  logic                             mul_valid_r;
  logic [PROD_W-1:0]                prod_r [DIM_COUNT];
  logic [DIM_COUNT-1:0][SIZE_W-1:0] mul_coord_r;

  logic                             add_valid_r;
  logic [SUM_W-1:0]                 sum01_r;
  logic [SUM_W-1:0]                 sum23_r;
  logic [DIM_COUNT-1:0][SIZE_W-1:0] add_coord_r;

  logic                             out_valid_r;
  logic [DIM_COUNT-1:0][SIZE_W-1:0] out_coord_r;
  logic [OFFSET_W-1:0]              out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DIM_COUNT; d++) begin
        dim_size_r[d] <= SIZE_W'(1);
        stride_r[d]   <= (d == DIM_COUNT - 1) ? STRIDE_W'(1) : '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DIM_SIZE_0: dim_size_r[0] <= cfg_wdata[SIZE_W-1:0];
        CFG_DIM_SIZE_1: dim_size_r[1] <= cfg_wdata[SIZE_W-1:0];
        CFG_DIM_SIZE_2: dim_size_r[2] <= cfg_wdata[SIZE_W-1:0];
        CFG_DIM_SIZE_3: dim_size_r[3] <= cfg_wdata[SIZE_W-1:0];
        CFG_STRIDE_0:   stride_r[0]   <= cfg_wdata[STRIDE_W-1:0];
        CFG_STRIDE_1:   stride_r[1]   <= cfg_wdata[STRIDE_W-1:0];
        CFG_STRIDE_2:   stride_r[2]   <= cfg_wdata[STRIDE_W-1:0];
        CFG_STRIDE_3:   stride_r[3]   <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // inactive leading dims and size zero divide by one
  always_comb begin
    for (int d = 0; d < DIM_COUNT; d++) begin
      div_size[d] = (d < FIRST_DIM || dim_size_r[d] == '0) ? SIZE_W'(1) : dim_size_r[d];
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    chain[DIM_COUNT].valid = in_valid;
    chain[DIM_COUNT].rest  = in_linear_index;
    chain[DIM_COUNT].coord = '0;
  end

  for (genvar d = DIM_COUNT - 1; d >= 0; d--) begin : g_dim
    stog_div #(
      .DIM (d)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .divisor  (div_size[d]),
      .item_in  (chain[d+1]),
      .item_out (chain[d])
    );
  end

  always_comb begin
    for (int d = 0; d < DIM_COUNT; d++) begin
      prod_nxt[d] = PROD_W'(chain[0].coord[d]) * PROD_W'(stride_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      add_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      mul_valid_r <= chain[0].valid;
      add_valid_r <= mul_valid_r;
      out_valid_r <= add_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < DIM_COUNT; d++) begin
        prod_r[d] <= prod_nxt[d];
      end
      mul_coord_r  <= chain[0].coord;
      sum01_r      <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]);
      sum23_r      <= SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
      add_coord_r  <= mul_coord_r;
      out_offset_r <= OFFSET_W'(sum01_r) + OFFSET_W'(sum23_r);
      out_coord_r  <= add_coord_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coord_0        = out_coord_r[0];
  assign out_coord_1        = out_coord_r[1];
  assign out_coord_2        = out_coord_r[2];
  assign out_coord_3        = out_coord_r[3];
  assign out_element_offset = out_offset_r;

  `STOG_ASSERT(a_offset_range, clk, rst_n, out_valid_r |-> out_offset_r[OFFSET_W-1:SUM_W+1] == '0)
  `STOG_ASSERT(a_hold_on_stall, clk, rst_n, add_valid_r && !adv |=> add_valid_r)
  `STOG_ASSERT_NR(a_reset_clears, clk, !rst_n |=> !out_valid_r && !add_valid_r && !mul_valid_r)

endmodule
